// ----- sv/stkpp_pkg.sv -----
// Shared widths, slot type and register codes for the spectral top-K peak picker.
package stkpp_pkg;

  localparam int unsigned COEF_W  = 32;
  localparam int unsigned POWER_W = 63;
  localparam int unsigned BIN_W   = 16;
  localparam int unsigned RANK_W  = 6;

  localparam logic [BIN_W-1:0] BAND_LOW_RST  = 16'd10;
  localparam logic [BIN_W-1:0] BAND_HIGH_RST = 16'd20000;

  // One list entry; also the record that travels down the cell row.
  typedef struct packed {
    logic               valid;
    logic [POWER_W-1:0] power;
    logic [BIN_W-1:0]   bin;
  } slot_t;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_BAND_LOW  = 1'b0,
    REG_BAND_HIGH = 1'b1
  } reg_idx_e;

endpackage

// ----- sv/stkpp_power.sv -----
// Three-stage squared-magnitude pipeline: absolute value, squares, sum with saturation.
module stkpp_power import stkpp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [COEF_W-1:0] real_i,
  input  logic signed [COEF_W-1:0] imag_i,
  input  logic [BIN_W-1:0]         bin_i,
  output slot_t                    slot_o
);

  logic                  valid0_q, valid1_q;
  logic [COEF_W-1:0]     mre_q, mim_q, mre_d, mim_d;
  logic [BIN_W-1:0]      bin0_q, bin1_q;
  logic [2*COEF_W-1:0]   sqr_q, sqi_q, sqr_d, sqi_d, sum_d;
  slot_t                 slot_q, slot_d;

  always_comb begin
    mre_d = real_i[COEF_W-1] ? (~real_i + 32'd1) : real_i;
    mim_d = imag_i[COEF_W-1] ? (~imag_i + 32'd1) : imag_i;
    sqr_d = (2*COEF_W)'(mre_q) * (2*COEF_W)'(mre_q);
    sqi_d = (2*COEF_W)'(mim_q) * (2*COEF_W)'(mim_q);
    // both squares are at most 2^62, so the sum fits in 64 bits
    sum_d = sqr_q + sqi_q;
    slot_d.valid = valid1_q && (sum_d != '0);
    slot_d.power = sum_d[2*COEF_W-1] ? {POWER_W{1'b1}} : sum_d[POWER_W-1:0];
    slot_d.bin   = bin1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
      valid1_q <= 1'b0;
      slot_q   <= '0;
    end else begin
      valid0_q <= valid_i;
      valid1_q <= valid0_q;
      slot_q   <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mre_q  <= mre_d;
    mim_q  <= mim_d;
    bin0_q <= bin_i;
    sqr_q  <= sqr_d;
    sqi_q  <= sqi_d;
    bin1_q <= bin0_q;
  end

  assign slot_o = slot_q;

endmodule

// ----- sv/stkpp_cell.sv -----
// One cell of the insertion row: holds a list entry and passes a travelling entry on.
module stkpp_cell import stkpp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  slot_t carry_i,
  input  slot_t below_i,
  output slot_t held_o,
  output slot_t carry_o
);

  slot_t held_q, held_d, carry_q, carry_d;

  always_comb begin
    held_d  = held_q;
    carry_d = carry_i;
    if (shift_i) begin
      // unload: move the list one place toward the head
      held_d        = below_i;
      carry_d.valid = 1'b0;
    end else if (carry_i.valid) begin
      if (!held_q.valid || (carry_i.power > held_q.power)) begin
        // take the newcomer, push the old entry down the row
        held_d  = carry_i;
        carry_d = held_q;
      end else if (carry_i.power == held_q.power) begin
        carry_d.valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      carry_q <= '0;
    end else begin
      held_q  <= held_d;
      carry_q <= carry_d;
    end
  end

  assign held_o  = held_q;
  assign carry_o = carry_q;

endmodule

// ----- sv/spectral_top_k_peak_picker.sv -----
// Top level: band gate, power pipeline, insertion row of TOP_COUNT cells, unload and APB port.
// A bin passes through the power pipeline into the head cell, then travels cell by cell to the
// row tail. Bins are taken one per cycle within a frame. After the frame_end transaction the
// input stalls while the row settles, then the list is shifted out of the head cell one result
// per cycle unless m_axis_tready holds it back (TOP_COUNT results, set by the row length).
// Reset (asynchronous, active low) empties the list, zeroes the bin counter, restores the band.
module spectral_top_k_peak_picker import stkpp_pkg::*; #(
  parameter int unsigned TOP_COUNT = 64,
  parameter int unsigned MAX_BINS  = 65536
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // APB configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // input bins
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // bin_real[31:0], bin_imag[63:32]
  input  logic          s_axis_tlast,   // frame_end
  // ranked peaks
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [87:0]   m_axis_tdata,   // rank[5:0], peak_bin[21:6], peak_power[84:22], zero
  output logic          m_axis_tuser,   // slot_valid
  output logic          m_axis_tlast    // list_last
);

  localparam int unsigned POS_W = $clog2(MAX_BINS);
  localparam int unsigned CNT_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
  localparam int unsigned FL_W  = $clog2(TOP_COUNT + 4);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_BINS - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TOP_COUNT - 1);
  localparam logic [FL_W-1:0]  FL_LOAD  = FL_W'(TOP_COUNT + 3);

  typedef enum logic [1:0] {
    ST_RUN    = 2'd0,
    ST_FLUSH  = 2'd1,
    ST_UNLOAD = 2'd2
  } state_e;

  state_e             state_q, state_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [BIN_W-1:0]   band_low_q, band_low_d, band_high_q, band_high_d;
  logic [FL_W-1:0]    flush_q, flush_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [RANK_W-1:0]  rank_q, rank_d;
  logic [BIN_W-1:0]   obin_q, obin_d;
  logic [POWER_W-1:0] opower_q, opower_d;
  logic               oslot_q, oslot_d;
  logic               olast_q, olast_d;

  logic               in_acc, in_band, load_en, cfg_wr, addr_ok;
  logic [BIN_W-1:0]   pos_ext;
  slot_t              pwr_slot;
  slot_t              held  [TOP_COUNT];
  slot_t              carry [TOP_COUNT];

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign addr_ok = (paddr[1:0] == 2'b00);

  always_comb begin
    prdata = '0;
    if (addr_ok) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_BAND_LOW:  prdata = {16'd0, band_low_q};
        REG_BAND_HIGH: prdata = {16'd0, band_high_q};
        default:       prdata = '0;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_RUN);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pos_ext       = BIN_W'(pos_q);
  assign in_band       = (pos_ext >= band_low_q) && (pos_ext < band_high_q);
  assign load_en       = (state_q == ST_UNLOAD) && (!out_valid_q || m_axis_tready);

  stkpp_power u_power (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_acc && in_band),
    .real_i  (s_axis_tdata[31:0]),
    .imag_i  (s_axis_tdata[63:32]),
    .bin_i   (pos_ext),
    .slot_o  (pwr_slot)
  );

  for (genvar i = 0; i < TOP_COUNT; i++) begin : g_cell
    slot_t c_in, b_in;
    if (i == 0) begin : g_head
      assign c_in = pwr_slot;
    end else begin : g_mid
      assign c_in = carry[i-1];
    end
    if (i == TOP_COUNT - 1) begin : g_tail
      assign b_in = '0;
    end else begin : g_body
      assign b_in = held[i+1];
    end
    stkpp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (load_en),
      .carry_i (c_in),
      .below_i (b_in),
      .held_o  (held[i]),
      .carry_o (carry[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    flush_d     = flush_q;
    cnt_d       = cnt_q;
    band_low_d  = band_low_q;
    band_high_d = band_high_q;
    out_valid_d = out_valid_q;
    rank_d      = rank_q;
    obin_d      = obin_q;
    opower_d    = opower_q;
    oslot_d     = oslot_q;
    olast_d     = olast_q;

    if (cfg_wr && addr_ok) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_BAND_LOW:  band_low_d  = pwdata[BIN_W-1:0];
        REG_BAND_HIGH: band_high_d = pwdata[BIN_W-1:0];
        default:       ;
      endcase
    end

    if (in_acc) begin
      pos_d = (pos_q == POS_LAST) ? '0 : pos_q + POS_W'(1);
    end

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_RUN: begin
        if (in_acc && s_axis_tlast) begin
          pos_d   = '0;
          flush_d = FL_LOAD;
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // hold until the last wave has left the row
        if (flush_q == '0) begin
          cnt_d   = '0;
          state_d = ST_UNLOAD;
        end else begin
          flush_d = flush_q - FL_W'(1);
        end
      end
      ST_UNLOAD: begin
        if (load_en) begin
          out_valid_d = 1'b1;
          rank_d      = RANK_W'(cnt_q);
          obin_d      = held[0].valid ? held[0].bin : '0;
          opower_d    = held[0].valid ? held[0].power : '0;
          oslot_d     = held[0].valid;
          olast_d     = (cnt_q == CNT_LAST);
          cnt_d       = cnt_q + CNT_W'(1);
          if (cnt_q == CNT_LAST) begin
            state_d = ST_RUN;
          end
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      pos_q       <= '0;
      flush_q     <= '0;
      cnt_q       <= '0;
      band_low_q  <= BAND_LOW_RST;
      band_high_q <= BAND_HIGH_RST;
      out_valid_q <= 1'b0;
      rank_q      <= '0;
      obin_q      <= '0;
      opower_q    <= '0;
      oslot_q     <= 1'b0;
      olast_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      flush_q     <= flush_d;
      cnt_q       <= cnt_d;
      band_low_q  <= band_low_d;
      band_high_q <= band_high_d;
      out_valid_q <= out_valid_d;
      rank_q      <= rank_d;
      obin_q      <= obin_d;
      opower_q    <= opower_d;
      oslot_q     <= oslot_d;
      olast_q     <= olast_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, opower_q, obin_q, rank_q};
  assign m_axis_tuser  = oslot_q;
  assign m_axis_tlast  = olast_q;

  // the list must have settled before it is shifted out
  a_row_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UNLOAD) |-> (!carry[TOP_COUNT-1].valid && !pwr_slot.valid))
    else $error("insertion wave still in flight during unload");

  a_last_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (rank_q == RANK_W'(TOP_COUNT - 1))))
    else $error("list_last does not match final rank");

  a_head_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (TOP_COUNT > 1 && held[TOP_COUNT > 1 ? 1 : 0].valid) |-> held[0].valid)
    else $error("second slot filled while head slot empty");

  a_unload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_en && cnt_q == CNT_LAST) |=> (state_q == ST_RUN))
    else $error("unload did not end after the last slot");

endmodule
